// ----- hdl/vsms_pkg.sv -----
// Shared types and constants for the vector set mean and deviation block.
package vsms_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECTED_TAG  = 8'd1;

	localparam int DIV_STEPS   = 64;
	localparam int DIV_CNT_W   = 6;
	localparam int SQRT_STEPS  = 32;
	localparam int SQRT_CNT_W  = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_SQR,
		ST_LD_RT,
		ST_LD_RT_W,
		ST_STORE,
		ST_CLOSE,
		ST_DIV,
		ST_DIV_W,
		ST_P2_RD,
		ST_P2_SQR,
		ST_STD_RT,
		ST_STD_RT_W,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               sel;
		logic [31:0]        mag;
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} entry_t;

	typedef struct packed {
		logic in_stall;
		logic div_start;
		logic sqrt_start;
		logic mem_we;
		logic fin_go;
	} ctl_t;

endpackage

// ----- hdl/vector_set_mean_std.sv -----
// Top level: loads a vector set, then gives mean and population deviation of the selection.
//
// Input channel (in_valid/in_stall) carries one Q16.16 vector with its tag and a
// last_item mark per transfer. in_stall is high whenever the sequencer is busy.
// A selected vector passes through three squares on the shared multiplier, then a
// 32-step root for its magnitude; an unselected one goes straight to the store.
// The transfer with last_item closes the set; if any vector is selected it runs four
// 64-step divisions for the means, a second pass of each stored vector through the
// multiplier, then four 64-step divisions and four 32-step roots. The divider and
// root units produce one bit per cycle.
// Output channel (out_valid/out_stall) holds one result in an output register.
// While it stalls the block keeps loading the next set; a second result waits in
// the final state until the register frees up.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the tag filter;
// they apply to vectors accepted afterwards.
// Reset clears the sequencer, counts and sums; stored vectors are not cleared and
// only entries written in the current set are read back.
// A vector arriving with the store full is dropped, but its last_item mark still
// closes the set.
module vector_set_mean_std #(
	parameter int MAX_ITEMS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [31:0]                  vec_x,
	input  logic signed [31:0]                  vec_y,
	input  logic signed [31:0]                  vec_z,
	input  logic [15:0]                         item_tag,
	input  logic                                last_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  mean_x,
	output logic signed [31:0]                  mean_y,
	output logic signed [31:0]                  mean_z,
	output logic [31:0]                         mean_norm,
	output logic [31:0]                         std_x,
	output logic [31:0]                         std_y,
	output logic [31:0]                         std_z,
	output logic [31:0]                         std_norm,
	output logic                                empty_set,
	output logic [8:0]                          selected_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vsms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vsms_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W  = $clog2(MAX_ITEMS);
	localparam int SUM_W  = 32 + CNT_W;
	localparam int NSUM_W = 32 + CNT_W;

	vsms_pkg::state_t state_q, state_d;
	vsms_pkg::ctl_t   ctl;

	// configuration
	logic        fen_q;
	logic [15:0] stag_q;

	// current vector
	logic signed [31:0] x_q, y_q, z_q;
	logic               sel_q, last_q;
	logic [31:0]        mag_q;
	logic [63:0]        acc_q;

	// set state
	logic [CNT_W-1:0]        load_cnt_q, sel_cnt_q;
	logic signed [SUM_W-1:0] sx_q, sy_q, sz_q;
	logic [NSUM_W-1:0]       sn_q;
	logic [63:0]             ssum_q [4];
	logic [31:0]             mean_q [4];
	logic [31:0]             std_q  [4];

	// sequencing
	logic [2:0]       kk_q;
	logic [2:0]       cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             neg_q;

	// shared square pipe
	logic [31:0]         op_q;
	logic [63:0]         prod_q;
	logic signed [33:0]  a_ext, m_ext, dev, dev_abs;
	logic [2:0]          pipe_end;
	logic [1:0]          acc_idx;
	logic [64:0]         sat_sum;

	// store
	vsms_pkg::entry_t mem_q [MAX_ITEMS];
	vsms_pkg::entry_t rd_q;
	vsms_pkg::entry_t wr_ent;

	// units
	logic [63:0]             div_dvd;
	logic                    div_neg;
	logic signed [SUM_W-1:0] ssel;
	logic [SUM_W-1:0]        sabs;
	logic                    div_done;
	logic [63:0]             div_quot;
	logic [63:0]             quot_neg;
	logic [63:0]             sqrt_opd;
	logic                    sqrt_done;
	logic [31:0]             sqrt_root;

	logic                    accept;
	logic                    sel_in;
	logic                    has_room;
	logic                    last_idx;
	logic [CNT_W+8:0]        cnt_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = ctl.in_stall;
	assign accept    = in_valid && !ctl.in_stall;
	assign sel_in    = !fen_q || (item_tag == stag_q);
	assign has_room  = load_cnt_q < CNT_W'(MAX_ITEMS);
	assign last_idx  = (CNT_W'(idx_q) + CNT_W'(1)) == load_cnt_q;
	assign pipe_end  = (state_q == vsms_pkg::ST_P2_SQR) ? 3'd5 : 3'd4;
	assign acc_idx   = 2'(cnt_q - 3'd2);
	assign sat_sum   = {1'b0, ssum_q[acc_idx]} + {1'b0, prod_q};
	assign cnt_ext   = {9'b0, sel_cnt_q};

	// operand of the square pipe: value minus its mean (zero while loading)
	always_comb begin
		a_ext = '0;
		m_ext = '0;
		if (state_q == vsms_pkg::ST_P2_SQR) begin
			case (cnt_q[1:0])
				2'd0: begin
					a_ext = 34'(rd_q.x);
					m_ext = 34'(signed'(mean_q[0]));
				end
				2'd1: begin
					a_ext = 34'(rd_q.y);
					m_ext = 34'(signed'(mean_q[1]));
				end
				2'd2: begin
					a_ext = 34'(rd_q.z);
					m_ext = 34'(signed'(mean_q[2]));
				end
				default: begin
					a_ext = signed'({2'b00, rd_q.mag});
					m_ext = signed'({2'b00, mean_q[3]});
				end
			endcase
		end else begin
			case (cnt_q[1:0])
				2'd0:    a_ext = 34'(x_q);
				2'd1:    a_ext = 34'(y_q);
				2'd2:    a_ext = 34'(z_q);
				default: a_ext = '0;
			endcase
		end
		dev     = a_ext - m_ext;
		dev_abs = dev[33] ? -dev : dev;
	end

	// divider operand: magnitudes of sums, then the square sums
	always_comb begin
		ssel = '0;
		case (kk_q)
			3'd0:    ssel = sx_q;
			3'd1:    ssel = sy_q;
			3'd2:    ssel = sz_q;
			default: ssel = '0;
		endcase
		sabs    = ssel[SUM_W-1] ? unsigned'(-ssel) : unsigned'(ssel);
		div_neg = ssel[SUM_W-1];
		if (kk_q == 3'd3) begin
			div_dvd = 64'(sn_q);
		end else if (kk_q[2]) begin
			div_dvd = ssum_q[kk_q[1:0]];
		end else begin
			div_dvd = 64'(sabs);
		end
	end

	assign quot_neg = -div_quot;
	assign sqrt_opd = (state_q == vsms_pkg::ST_LD_RT) ? acc_q : div_quot;

	vsms_div #(.DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_dvd),
		.divisor  (sel_cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	vsms_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.sqrt_start),
		.operand (sqrt_opd),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vsms_pkg::ST_IDLE: begin
				if (accept) begin
					if (has_room) begin
						state_d = sel_in ? vsms_pkg::ST_LD_SQR : vsms_pkg::ST_STORE;
					end else if (last_item) begin
						state_d = vsms_pkg::ST_CLOSE;
					end
				end
			end
			vsms_pkg::ST_LD_SQR: begin
				if (cnt_q == pipe_end) state_d = vsms_pkg::ST_LD_RT;
			end
			vsms_pkg::ST_LD_RT:   state_d = vsms_pkg::ST_LD_RT_W;
			vsms_pkg::ST_LD_RT_W: begin
				if (sqrt_done) state_d = vsms_pkg::ST_STORE;
			end
			vsms_pkg::ST_STORE: begin
				state_d = last_q ? vsms_pkg::ST_CLOSE : vsms_pkg::ST_IDLE;
			end
			vsms_pkg::ST_CLOSE: begin
				state_d = (sel_cnt_q == '0) ? vsms_pkg::ST_FIN : vsms_pkg::ST_DIV;
			end
			vsms_pkg::ST_DIV:   state_d = vsms_pkg::ST_DIV_W;
			vsms_pkg::ST_DIV_W: begin
				if (div_done) begin
					if (kk_q[2]) state_d = vsms_pkg::ST_STD_RT;
					else if (kk_q == 3'd3) state_d = vsms_pkg::ST_P2_RD;
					else state_d = vsms_pkg::ST_DIV;
				end
			end
			vsms_pkg::ST_P2_RD:  state_d = vsms_pkg::ST_P2_SQR;
			vsms_pkg::ST_P2_SQR: begin
				if (cnt_q == pipe_end) begin
					state_d = last_idx ? vsms_pkg::ST_DIV : vsms_pkg::ST_P2_RD;
				end
			end
			vsms_pkg::ST_STD_RT:   state_d = vsms_pkg::ST_STD_RT_W;
			vsms_pkg::ST_STD_RT_W: begin
				if (sqrt_done) begin
					state_d = (kk_q == 3'd7) ? vsms_pkg::ST_FIN : vsms_pkg::ST_DIV;
				end
			end
			vsms_pkg::ST_FIN: begin
				if (!out_valid || !out_stall) state_d = vsms_pkg::ST_IDLE;
			end
			default: state_d = vsms_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl            = '0;
		ctl.in_stall   = (state_q != vsms_pkg::ST_IDLE);
		ctl.div_start  = (state_q == vsms_pkg::ST_DIV);
		ctl.sqrt_start = (state_q == vsms_pkg::ST_LD_RT) || (state_q == vsms_pkg::ST_STD_RT);
		ctl.mem_we     = (state_q == vsms_pkg::ST_STORE);
		ctl.fin_go     = (state_q == vsms_pkg::ST_FIN) && (!out_valid || !out_stall);
	end

	// control and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vsms_pkg::ST_IDLE;
			fen_q      <= 1'b0;
			stag_q     <= '0;
			load_cnt_q <= '0;
			sel_cnt_q  <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			sz_q       <= '0;
			sn_q       <= '0;
			for (int i = 0; i < 4; i++) ssum_q[i] <= '0;
			kk_q       <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				case (cfg_index)
					vsms_pkg::REG_FILTER_ENABLE: fen_q  <= cfg_data[0];
					vsms_pkg::REG_SELECTED_TAG:  stag_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			// step the square pipe; hold at zero elsewhere
			if (state_q == vsms_pkg::ST_LD_SQR || state_q == vsms_pkg::ST_P2_SQR) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end

			if (ctl.mem_we) begin
				load_cnt_q <= load_cnt_q + CNT_W'(1);
				if (sel_q) begin
					sel_cnt_q <= sel_cnt_q + CNT_W'(1);
					sx_q      <= sx_q + SUM_W'(x_q);
					sy_q      <= sy_q + SUM_W'(y_q);
					sz_q      <= sz_q + SUM_W'(z_q);
					sn_q      <= sn_q + NSUM_W'(mag_q);
				end
			end

			// saturating accumulate of squared deviations
			if (state_q == vsms_pkg::ST_P2_SQR && cnt_q >= 3'd2 && rd_q.sel) begin
				ssum_q[acc_idx] <= sat_sum[64] ? '1 : sat_sum[63:0];
			end

			if (state_q == vsms_pkg::ST_CLOSE) kk_q <= '0;
			if (state_q == vsms_pkg::ST_DIV_W && div_done && !kk_q[2]) begin
				kk_q <= kk_q + 3'd1;
				idx_q <= '0;
			end
			if (state_q == vsms_pkg::ST_STD_RT_W && sqrt_done) kk_q <= kk_q + 3'd1;
			if (state_q == vsms_pkg::ST_P2_SQR && cnt_q == pipe_end && !last_idx) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			// result into output register, then clear for the next set
			if (ctl.fin_go) begin
				out_valid  <= 1'b1;
				load_cnt_q <= '0;
				sel_cnt_q  <= '0;
				sx_q       <= '0;
				sy_q       <= '0;
				sz_q       <= '0;
				sn_q       <= '0;
				for (int i = 0; i < 4; i++) ssum_q[i] <= '0;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= vec_x;
			y_q    <= vec_y;
			z_q    <= vec_z;
			sel_q  <= sel_in;
			last_q <= last_item;
			acc_q  <= '0;
		end

		if (state_q == vsms_pkg::ST_LD_SQR || state_q == vsms_pkg::ST_P2_SQR) begin
			op_q   <= dev_abs[31:0];
			prod_q <= op_q * op_q;
			if (state_q == vsms_pkg::ST_LD_SQR && cnt_q >= 3'd2) acc_q <= acc_q + prod_q;
		end

		if (state_q == vsms_pkg::ST_LD_RT_W && sqrt_done) mag_q <= sqrt_root;

		if (ctl.div_start) neg_q <= div_neg;
		if (state_q == vsms_pkg::ST_DIV_W && div_done && !kk_q[2]) begin
			if (kk_q == 3'd3) begin
				mean_q[3] <= (|div_quot[63:32]) ? '1 : div_quot[31:0];
			end else begin
				mean_q[kk_q[1:0]] <= neg_q ? quot_neg[31:0] : div_quot[31:0];
			end
		end
		if (state_q == vsms_pkg::ST_STD_RT_W && sqrt_done) std_q[kk_q[1:0]] <= sqrt_root;

		if (ctl.fin_go) begin
			if (sel_cnt_q == '0) begin
				mean_x    <= '0;
				mean_y    <= '0;
				mean_z    <= '0;
				mean_norm <= '0;
				std_x     <= '0;
				std_y     <= '0;
				std_z     <= '0;
				std_norm  <= '0;
			end else begin
				mean_x    <= signed'(mean_q[0]);
				mean_y    <= signed'(mean_q[1]);
				mean_z    <= signed'(mean_q[2]);
				mean_norm <= mean_q[3];
				std_x     <= std_q[0];
				std_y     <= std_q[1];
				std_z     <= std_q[2];
				std_norm  <= std_q[3];
			end
			empty_set      <= (sel_cnt_q == '0);
			selected_count <= cnt_ext[8:0];
		end
	end

	// vector store
	always_comb begin
		wr_ent.sel = sel_q;
		wr_ent.mag = mag_q;
		wr_ent.x   = x_q;
		wr_ent.y   = y_q;
		wr_ent.z   = z_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_we) mem_q[load_cnt_q[IDX_W-1:0]] <= wr_ent;
		rd_q <= mem_q[idx_q];
	end
endmodule

// ----- hdl/vsms_div.sv -----
// Iterative restoring divider: 64-bit unsigned dividend, one quotient bit per cycle.
module vsms_div #(
	parameter int DVS_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	localparam int CW = vsms_pkg::DIV_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(vsms_pkg::DIV_STEPS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [63:0]      dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_dif;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[63]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_dif = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

// ----- hdl/vsms_isqrt.sv -----
// Iterative integer square root of a 64-bit value, one root bit per cycle.
module vsms_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [31:0] root
);
	localparam int CW = vsms_pkg::SQRT_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(vsms_pkg::SQRT_STEPS - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   val_q;
	logic [33:0]   rem_q;
	logic [31:0]   root_q;
	logic [33:0]   rem_sh;
	logic [33:0]   trial;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q[31:0], val_q[63:62]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[61:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- hdl/vsms_chk.sv -----
// Port-level checker for the vector set mean and deviation block, with its bind.
module vsms_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] mean_x,
	input logic signed [31:0] mean_y,
	input logic signed [31:0] mean_z,
	input logic [31:0]        mean_norm,
	input logic [31:0]        std_x,
	input logic [31:0]        std_y,
	input logic [31:0]        std_z,
	input logic [31:0]        std_norm,
	input logic               empty_set,
	input logic [8:0]         selected_count
);
	// an empty selection reports all statistics as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_set |-> mean_x == 0 && mean_y == 0 && mean_z == 0 &&
		mean_norm == 0 && std_x == 0 && std_y == 0 && std_z == 0 &&
		std_norm == 0 && selected_count == 0)
		else $error("empty set with nonzero statistics");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean_x) && $stable(std_norm) &&
		$stable(selected_count) && $stable(empty_set))
		else $error("stalled result changed");

	// a result appears only at the end of busy sequencing
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced while idle");
endmodule

bind vector_set_mean_std vsms_chk u_vsms_chk (.*);
